// ----- design/shp_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment header parser package
// Shared types and constants: beat payloads, result kinds, queue entry.
// ----------------------------------------------------------------------------
package shp_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_ENTRY     = 3'd1,
    KIND_NAME_BYTE = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_TRUNC     = 3'd5
  } kind_e;

  localparam int HeaderBytes = 22;
  localparam int EntryBytes  = 8;
  localparam int IdxW        = 5;
  localparam int PosW        = 33;

  // Magic 'P','T','S','G', index 0 first
  localparam logic [3:0][7:0] MAGIC = {8'h47, 8'h53, 8'h54, 8'h50};

  // Run queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    kind_e             kind;
    logic [15:0]       version;
    logic [15:0]       header_flags;
    logic [63:0]       start_ms;
    logic [31:0]       rec_count;
    logic [15:0]       tgt_count;
    logic [15:0]       entry_id;
    logic [31:0]       entry_address;
    logic [15:0]       name_length;
    logic [7:0]        name_char;
    logic [PosW-1:0]   data_start;
    logic              last_of_run;
  } out_t;

  // All results caused by one input byte: a primary result and an optional
  // trailing done or truncated result.
  typedef struct packed {
    out_t              prim;
    logic              sec_valid;
    logic              sec_done;
    logic [PosW-1:0]   sec_offset;
  } run_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- design/segment_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// Segment header parser
// Parses a segment file byte stream into header, entry, name and done beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_i) takes one file byte per
//   beat, with final_byte set on the last byte of a segment.
//   Output channel (out_valid_o / out_stall_i / out_o) delivers results; each
//   byte causes zero, one or two results, last_of_run marks the last of them.
//   Path: a byte's results pass from the front end through the four-entry
//   run queue into the output register, which then presents them.
//   Throughput: one byte per cycle while each byte causes at most one result
//   and the output is not stalled; a byte with two results holds the output
//   register for both, and the run queue absorbs that until it fills.
//   in_stall_o rises only when the run queue is full; a stalled output holds
//   its beat and back-pressure reaches the input once the queue fills.
//   Reset clears the parse state (expects the magic next) and empties the
//   queue and output register. After the final byte the parser restarts.
// ----------------------------------------------------------------------------
module segment_header_parser_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  shp_pkg::in_t   in_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output shp_pkg::out_t  out_o,
  input  logic           out_stall_i
);
  import shp_pkg::*;

  q_status_t q_status;
  run_t      push_data;
  run_t      head;
  logic      push;
  logic      pop;

  shp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .run_o      (push_data)
  );

  shp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  shp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ----- design/shp_front.sv -----
// ----------------------------------------------------------------------------
// Segment header parser front end
// Accepts input beats, tracks the file layout and builds at most one run per byte.
// ----------------------------------------------------------------------------
module shp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  shp_pkg::in_t       in_i,
  output logic               in_stall_o,
  input  shp_pkg::q_status_t q_status_i,
  output logic               push_o,
  output shp_pkg::run_t      run_o
);
  import shp_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_ENTRY  = 2'd1;
  localparam logic [1:0] PH_NAME   = 2'd2;
  localparam logic [1:0] PH_IGNORE = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     version_q, version_d;
  logic [15:0]     flags_q, flags_d;
  logic [63:0]     start_q, start_d;
  logic [31:0]     count_q, count_d;
  logic [15:0]     entries_q, entries_d;
  logic [15:0]     id_q, id_d;
  logic [31:0]     addr_q, addr_d;
  logic [15:0]     name_q, name_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic            accept;
  logic            prim_valid;
  logic [7:0]      b;
  logic [IdxW-1:0] k;
  logic [1:0]      addr_sel;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign b          = in_i.data_byte;
  assign k          = idx_q;
  assign addr_sel   = k[1:0] - 2'd2;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    version_d  = version_q;
    flags_d    = flags_q;
    start_d    = start_q;
    count_d    = count_q;
    entries_d  = entries_q;
    id_d       = id_q;
    addr_d     = addr_q;
    name_d     = name_q;
    pos_d      = pos_q;
    run_o      = '0;
    prim_valid = 1'b0;

    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (k < IdxW'(4)) begin
            if (b != MAGIC[k[1:0]]) begin
              prim_valid      = 1'b1;
              run_o.prim.kind = KIND_BAD_MAGIC;
              phase_d         = PH_IGNORE;
            end
          end else if (k < IdxW'(6)) begin
            version_d[{k[0], 3'b000} +: 8] = b;
          end else if (k < IdxW'(8)) begin
            flags_d[{k[0], 3'b000} +: 8] = b;
          end else if (k < IdxW'(16)) begin
            start_d[{k[2:0], 3'b000} +: 8] = b;
          end else if (k < IdxW'(20)) begin
            count_d[{k[1:0], 3'b000} +: 8] = b;
          end else begin
            entries_d[{k[0], 3'b000} +: 8] = b;
          end
          if (phase_d == PH_HEADER) begin
            pos_d = pos_q + PosW'(1);
            idx_d = idx_q + IdxW'(1);
            if (k == IdxW'(HeaderBytes - 1)) begin
              prim_valid              = 1'b1;
              run_o.prim.kind         = KIND_HEADER;
              run_o.prim.version      = version_d;
              run_o.prim.header_flags = flags_d;
              run_o.prim.start_ms     = start_d;
              run_o.prim.rec_count    = count_d;
              run_o.prim.tgt_count    = entries_d;
              idx_d                   = '0;
              if (entries_d == 16'd0) begin
                run_o.sec_valid  = 1'b1;
                run_o.sec_done   = 1'b1;
                run_o.sec_offset = pos_d;
                phase_d          = PH_IGNORE;
              end else begin
                phase_d = PH_ENTRY;
              end
            end
          end
        end
        PH_ENTRY: begin
          if (k < IdxW'(2)) begin
            id_d[{k[0], 3'b000} +: 8] = b;
          end else if (k < IdxW'(6)) begin
            addr_d[{addr_sel, 3'b000} +: 8] = b;
          end else begin
            name_d[{k[0], 3'b000} +: 8] = b;
          end
          pos_d = pos_q + PosW'(1);
          idx_d = idx_q + IdxW'(1);
          if (k == IdxW'(EntryBytes - 1)) begin
            prim_valid               = 1'b1;
            run_o.prim.kind          = KIND_ENTRY;
            run_o.prim.entry_id      = id_d;
            run_o.prim.entry_address = addr_d;
            run_o.prim.name_length   = name_d;
            idx_d                    = '0;
            entries_d                = entries_q - 16'd1;
            if (name_d != 16'd0) begin
              phase_d = PH_NAME;
            end else if (entries_d == 16'd0) begin
              run_o.sec_valid  = 1'b1;
              run_o.sec_done   = 1'b1;
              run_o.sec_offset = pos_d;
              phase_d          = PH_IGNORE;
            end else begin
              phase_d = PH_ENTRY;
            end
          end
        end
        PH_NAME: begin
          prim_valid           = 1'b1;
          run_o.prim.kind      = KIND_NAME_BYTE;
          run_o.prim.name_char = b;
          pos_d                = pos_q + PosW'(1);
          name_d               = name_q - 16'd1;
          if (name_d == 16'd0) begin
            if (entries_q == 16'd0) begin
              run_o.sec_valid  = 1'b1;
              run_o.sec_done   = 1'b1;
              run_o.sec_offset = pos_d;
              phase_d          = PH_IGNORE;
            end else begin
              phase_d = PH_ENTRY;
            end
          end
        end
        PH_IGNORE: begin
        end
        default: begin
        end
      endcase

      if (in_i.final_byte) begin
        // truncated unless the file already ended cleanly or failed
        if (phase_d != PH_IGNORE) begin
          if (prim_valid) begin
            run_o.sec_valid = 1'b1;
            run_o.sec_done  = 1'b0;
          end else begin
            prim_valid      = 1'b1;
            run_o.prim.kind = KIND_TRUNC;
          end
        end
        phase_d   = PH_HEADER;
        idx_d     = '0;
        version_d = '0;
        flags_d   = '0;
        start_d   = '0;
        count_d   = '0;
        entries_d = '0;
        id_d      = '0;
        addr_d    = '0;
        name_d    = '0;
        pos_d     = '0;
      end
    end
  end

  assign push_o = prim_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      idx_q     <= '0;
      version_q <= '0;
      flags_q   <= '0;
      start_q   <= '0;
      count_q   <= '0;
      entries_q <= '0;
      id_q      <= '0;
      addr_q    <= '0;
      name_q    <= '0;
      pos_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      version_q <= version_d;
      flags_q   <= flags_d;
      start_q   <= start_d;
      count_q   <= count_d;
      entries_q <= entries_d;
      id_q      <= id_d;
      addr_q    <= addr_d;
      name_q    <= name_d;
      pos_q     <= pos_d;
    end
  end

endmodule

// ----- design/shp_queue.sv -----
// ----------------------------------------------------------------------------
// Segment header parser run queue
// Small circular buffer of runs between the front end and the back end.
// ----------------------------------------------------------------------------
module shp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  shp_pkg::run_t      push_data_i,
  input  logic               pop_i,
  output shp_pkg::run_t      head_o,
  output shp_pkg::q_status_t status_o
);
  import shp_pkg::*;

  run_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign head_o         = mem_q[rd_ptr_q];
  assign count_d        = count_q + QCntW'(push_i) - QCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("run queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full run queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty run queue");
`endif

endmodule

// ----- design/shp_back.sv -----
// ----------------------------------------------------------------------------
// Segment header parser back end
// Unpacks queued runs into output beats held in the output register.
// ----------------------------------------------------------------------------
module shp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shp_pkg::run_t      head_i,
  input  shp_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output shp_pkg::out_t      out_o,
  input  logic               out_stall_i
);
  import shp_pkg::*;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic half_q, half_d;   // primary of head run already sent
  logic load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    half_d      = half_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !q_status_i.empty;
      if (!q_status_i.empty) begin
        if (!half_q) begin
          out_d             = head_i.prim;
          out_d.last_of_run = !head_i.sec_valid;
          if (head_i.sec_valid) begin
            half_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_d             = '0;
          out_d.kind        = head_i.sec_done ? KIND_DONE : KIND_TRUNC;
          out_d.data_start  = head_i.sec_done ? head_i.sec_offset : '0;
          out_d.last_of_run = 1'b1;
          pop_o             = 1'b1;
          half_d            = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_half_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> !q_status_i.empty)
    else $error("split run with empty queue");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_DONE) |-> out_q.last_of_run)
    else $error("done beat not last of run");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_TRUNC) |-> out_q.last_of_run)
    else $error("truncated beat not last of run");
`endif

endmodule
